>>> rtl/fifo_cache_miss_counter_core_assert.svh
// Assertion macros for the FIFO cache miss counter.
// Empty bodies when SYNTH is defined.
`ifndef FIFO_CACHE_MISS_COUNTER_CORE_ASSERT_SVH
`define FIFO_CACHE_MISS_COUNTER_CORE_ASSERT_SVH

`ifndef SYNTH
// Checked at each rising edge, off while reset is asserted.
`define FCMC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fcmc assertion failed");
// Checked at each rising edge, reset included.
`define FCMC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fcmc assertion failed");
`else
`define FCMC_ASSERT(lbl, clk, rstn, prop)
`define FCMC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/fcmc_pkg.sv
package fcmc_pkg;

  // Build-time sizes
  localparam int DEPTH     = 64;
  localparam int KEY_BITS  = 16;
  localparam int CAP_W     = 7;
  localparam int CNT_W     = 16;
  localparam int CAP_RESET = 64;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEFT_W    = $clog2(DEPTH + 1);

  // Request and response payloads
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last_request;
  } req_t;

  typedef struct packed {
    logic             was_miss;
    logic [CNT_W-1:0] miss_count;
    logic             list_done;
  } rsp_t;

  // Lookup token passed from cell to cell
  typedef struct packed {
    logic                vld;
    logic [KEY_BITS-1:0] key;
    logic                hit;
    logic [LEFT_W-1:0]   left;  // cells still in use ahead of the token
  } scan_t;

  // Store command broadcast to all cells
  typedef struct packed {
    logic                clr;
    logic [KEY_BITS-1:0] key;
  } store_cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

endpackage

>>> rtl/fcmc_cell.sv
module fcmc_cell import fcmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  scan_t      tok_i,
  output scan_t      tok_o,
  input  logic       wr_i,
  input  store_cmd_t cmd_i
);

  logic [KEY_BITS-1:0] key_q;
  logic                valid_q;
  scan_t               tok_q, tok_d;
  logic                match;

  // Local tag compare, only while this cell is within the capacity in use
  always_comb begin
    match = valid_q && (key_q == tok_i.key) && (tok_i.left != '0);
  end

  always_comb begin
    tok_d      = tok_i;
    tok_d.hit  = tok_i.hit | match;
    tok_d.left = (tok_i.left == '0) ? '0 : tok_i.left - LEFT_W'(1);
  end

  // Token stage to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Entry valid; list clear wins over an insert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.clr) begin
      valid_q <= 1'b0;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  // Entry key
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q <= cmd_i.key;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/fcmc_ctrl.sv
`include "fifo_cache_miss_counter_core_assert.svh"

module fcmc_ctrl import fcmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o,
  output scan_t            head_o,
  input  scan_t            tail_i,
  output logic [DEPTH-1:0] wr_sel_o,
  output store_cmd_t       cmd_o
);

  state_e             state_q, state_d;
  logic [CAP_W-1:0]   cap_q;
  logic [LEFT_W-1:0]  cap_eff;
  req_t               req_q;
  logic               launch_q;
  logic               hit_q;
  logic [IDX_W-1:0]   ptr_q;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   ptr_nxt;
  logic [LEFT_W-1:0]  slot_inc;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_new;
  logic               out_valid_q;
  rsp_t               out_rsp_q;
  logic               out_free;
  logic               accept;
  logic               commit;

  // Capacity in use: zero acts as one, clipped to the built depth
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = LEFT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = LEFT_W'(DEPTH);
    end else begin
      cap_eff = LEFT_W'(cap_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (tail_i.vld) state_d = ST_COMMIT;
      ST_COMMIT: if (out_free)   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i && (state_q == ST_IDLE);
    commit     = (state_q == ST_COMMIT) && out_free;
  end

  // Insert slot, pointer advance and saturating miss count
  always_comb begin
    slot     = (LEFT_W'(ptr_q) >= cap_eff) ? '0 : ptr_q;
    slot_inc = LEFT_W'(slot) + LEFT_W'(1);
    ptr_nxt  = (slot_inc >= cap_eff) ? '0 : slot_inc[IDX_W-1:0];
    if (hit_q || (cnt_q == '1)) begin
      cnt_new = cnt_q;
    end else begin
      cnt_new = cnt_q + CNT_W'(1);
    end
  end

  // At most one write select into the cell row, and the store command
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      wr_sel_o[i] = commit && !hit_q && (slot == IDX_W'(i));
    end
    cmd_o.clr = commit && req_q.last_request;
    cmd_o.key = req_q.key;
  end

  // Token launched into the first cell
  always_comb begin
    head_o.vld  = launch_q;
    head_o.key  = req_q.key;
    head_o.hit  = 1'b0;
    head_o.left = cap_eff;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_W'(CAP_RESET);
      launch_q    <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit) begin
        if (req_q.last_request) begin
          ptr_q <= '0;
          cnt_q <= '0;
        end else begin
          if (!hit_q) ptr_q <= ptr_nxt;
          cnt_q <= cnt_new;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (tail_i.vld) begin
      hit_q <= tail_i.hit;
    end
    if (commit) begin
      out_rsp_q.was_miss   <= !hit_q;
      out_rsp_q.miss_count <= cnt_new;
      out_rsp_q.list_done  <= req_q.last_request;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Checks
  `FCMC_ASSERT(a_tail_in_scan, clk_i, rst_ni, tail_i.vld |-> (state_q == ST_SCAN))
  `FCMC_ASSERT(a_one_write, clk_i, rst_ni, $onehot0(wr_sel_o))
  `FCMC_ASSERT(a_cnt_hold, clk_i, rst_ni, !commit |=> $stable(cnt_q))
  `FCMC_ASSERT(a_list_clear, clk_i, rst_ni,
               (commit && req_q.last_request) |=> (cnt_q == '0) && (ptr_q == '0))

endmodule

>>> rtl/fifo_cache_miss_counter_core.sv
// Channel   Valid        Stall        Payload
// request   in_valid_i   in_stall_o   in_req_i  (key, last_request)
// response  out_valid_o  out_stall_i  out_rsp_o (was_miss, miss_count, list_done)
// config    cfg_we_i     -            cfg_wdata_i (capacity)
//
// One request at a time: a lookup token walks the cell row one cell per cycle,
// and the result is committed once the token leaves the last cell.
// The response register holds one result; a new request is taken while it waits,
// and the commit cycle waits only if that register is still stalled.
// Reset clears valid bits, pointer, miss count, and sets capacity to 64.
module fifo_cache_miss_counter_core import fcmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o
);

  scan_t            tok [DEPTH+1];
  logic [DEPTH-1:0] wr_sel;
  store_cmd_t       cmd;

  // Sequencer, pointer, counter and response register
  fcmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .head_o      (tok[0]),
    .tail_i      (tok[DEPTH]),
    .wr_sel_o    (wr_sel),
    .cmd_o       (cmd)
  );

  // Row of entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fcmc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .wr_i   (wr_sel[g]),
      .cmd_i  (cmd)
    );
  end

endmodule
